>>> sv/ptts_pkg.sv
package ptts_pkg;

  localparam int TIME_W = 32;
  localparam int PER_W  = 16;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_SCHED  = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_ONESHOT = 2'd0,
    MODE_FDELAY  = 2'd1,
    MODE_FRATE   = 2'd2,
    MODE_BAD     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_FIRED  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIRE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic scan_start;
    logic scan_run;
    logic fire;
  } ptts_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic pend;
    logic last;
  } ptts_sts_t;

endpackage

>>> sv/periodic_timer_task_scheduler_unit.sv
// Timer slot scheduler. Schedule and cancel requests are answered with one
// result offered in the cycle after the transfer. A tick first scans the slot
// table, one slot per cycle through the table's single read port; each firing
// then costs a slot update plus a rescan that also decides whether the result
// is the last one, plus the output transfer. Input is stalled until the last
// result of the current item has been transferred, or until the scan ends for
// a tick with no slot due.
module periodic_timer_task_scheduler_unit import ptts_pkg::*; #(
  parameter int SLOTS     = 16,
  parameter int MAX_FIRES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [3:0]  slot,
  input  logic [15:0] delay,
  input  logic [15:0] period,
  input  logic [1:0]  mode,
  input  logic [3:0]  elapsed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [3:0]  fired_slot,
  output logic [31:0] fire_time,
  output logic        last,
  output logic        overflow
);

  ptts_cmd_t cmd;
  ptts_sts_t sts;

  ptts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  ptts_dp #(
    .SLOTS     (SLOTS),
    .MAX_FIRES (MAX_FIRES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .action     (action),
    .slot       (slot),
    .delay      (delay),
    .period     (period),
    .mode       (mode),
    .elapsed    (elapsed),
    .sts        (sts),
    .kind       (kind),
    .fired_slot (fired_slot),
    .fire_time  (fire_time),
    .last       (last),
    .overflow   (overflow)
  );

  a_idle_no_out: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid) else $error("output valid while idle");

  a_ovf_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> last) else $error("overflow without last");

  a_req_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_FIRED) |-> last && !overflow)
    else $error("request answer not final");

  a_fire_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.fire |=> cmd.scan_run) else $error("fire not followed by scan");

endmodule

>>> sv/ptts_ctrl.sv
module ptts_ctrl import ptts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic [1:0] action,
  input  logic      out_stall,
  input  ptts_sts_t sts,
  output ptts_cmd_t cmd,
  output logic      in_stall,
  output logic      out_valid
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (action_t'(action))
            ACT_TICK:              state_next = ST_SCAN;
            ACT_SCHED, ACT_CANCEL: state_next = ST_EMIT;
            default:               state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          priority if (sts.pend) state_next = ST_EMIT;
          else if (sts.found)    state_next = ST_FIRE;
          else                   state_next = ST_IDLE;
        end
      end
      ST_FIRE: state_next = ST_SCAN;
      ST_EMIT: begin
        if (!out_stall) state_next = sts.last ? ST_IDLE : ST_FIRE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state != ST_IDLE);
    out_valid      = (state == ST_EMIT);
    cmd.take       = (state == ST_IDLE) && in_valid;
    cmd.scan_start = (cmd.take && (action_t'(action) == ACT_TICK)) || (state == ST_FIRE);
    cmd.scan_run   = (state == ST_SCAN);
    cmd.fire       = (state == ST_FIRE);
  end

endmodule

>>> sv/ptts_dp.sv
module ptts_dp import ptts_pkg::*; #(
  parameter int SLOTS     = 16,
  parameter int MAX_FIRES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  ptts_cmd_t   cmd,
  input  logic [1:0]  action,
  input  logic [3:0]  slot,
  input  logic [15:0] delay,
  input  logic [15:0] period,
  input  logic [1:0]  mode,
  input  logic [3:0]  elapsed,
  output ptts_sts_t   sts,
  output logic [1:0]  kind,
  output logic [3:0]  fired_slot,
  output logic [31:0] fire_time,
  output logic        last,
  output logic        overflow
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IW = $clog2(SLOTS + 1);
  localparam int CW = $clog2(MAX_FIRES + 1);
  localparam int EW = TIME_W + PER_W + 2;

  logic [EW-1:0] mem [SLOTS];
  logic [EW-1:0] rdata;
  logic          we;
  logic [SW-1:0] waddr;
  logic [EW-1:0] wdata;

  logic [SLOTS-1:0] armed;
  logic [TIME_W-1:0] now;
  logic [IW-1:0] idx;
  logic          ev_valid;
  logic [SW-1:0] ev_idx;
  logic          found;
  logic [SW-1:0] best;
  logic [TIME_W-1:0] best_key;
  logic [TIME_W-1:0] best_due;
  logic [PER_W-1:0]  best_per;
  logic [1:0]        best_mode;
  logic [CW-1:0] cnt;
  logic          pend;
  logic          is_req;
  logic [1:0]    out_kind;
  logic [3:0]    out_slot;
  logic [TIME_W-1:0] out_time;

  logic [SW-1:0] sidx;
  logic          in_range;
  logic          sched_ok;
  logic          cancel_ok;
  logic [TIME_W-1:0] ev_due;
  logic [TIME_W-1:0] ev_diff;
  logic [TIME_W-1:0] ev_key;
  logic          ev_hit;
  logic [TIME_W-1:0] new_due;
  logic          at_cap;

  assign sidx      = SW'(slot);
  assign in_range  = (32'(slot) < SLOTS);
  assign sched_ok  = in_range && (mode_t'(mode) != MODE_BAD) && !armed[sidx]
                     && ((mode_t'(mode) == MODE_ONESHOT) || (period != '0));
  assign cancel_ok = in_range && armed[sidx];

  assign ev_due  = rdata[EW-1 -: TIME_W];
  assign ev_diff = ev_due - now;
  assign ev_key  = ev_diff ^ {1'b1, {(TIME_W-1){1'b0}}};
  assign ev_hit  = ev_valid && armed[ev_idx] && ((ev_diff == '0) || ev_diff[TIME_W-1]);

  assign new_due = (mode_t'(best_mode) == MODE_FDELAY) ? now + TIME_W'(best_per)
                                                       : best_due + TIME_W'(best_per);
  assign at_cap  = (cnt == CW'(MAX_FIRES));

  always_comb begin
    we    = 1'b0;
    waddr = sidx;
    wdata = {now + TIME_W'(delay), period, mode};
    if (cmd.take && (action_t'(action) == ACT_SCHED) && sched_ok) begin
      we = 1'b1;
    end else if (cmd.fire && (mode_t'(best_mode) != MODE_ONESHOT)) begin
      we    = 1'b1;
      waddr = best;
      wdata = {new_due, best_per, best_mode};
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[idx[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
    end else if (cmd.take && (action_t'(action) == ACT_SCHED) && sched_ok) begin
      armed[sidx] <= 1'b1;
    end else if (cmd.take && (action_t'(action) == ACT_CANCEL) && cancel_ok) begin
      armed[sidx] <= 1'b0;
    end else if (cmd.fire && (mode_t'(best_mode) == MODE_ONESHOT)) begin
      armed[best] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now      <= '0;
      idx      <= '0;
      ev_valid <= 1'b0;
      found    <= 1'b0;
      cnt      <= '0;
      pend     <= 1'b0;
      is_req   <= 1'b0;
    end else begin
      if (cmd.take) begin
        unique case (action_t'(action))
          ACT_TICK: begin
            now    <= now + TIME_W'(elapsed);
            cnt    <= '0;
            pend   <= 1'b0;
            is_req <= 1'b0;
          end
          ACT_SCHED: begin
            is_req <= 1'b1;
          end
          ACT_CANCEL: begin
            is_req <= 1'b1;
          end
          default: begin
            is_req <= 1'b0;
          end
        endcase
      end
      if (cmd.fire) begin
        cnt  <= cnt + 1'b1;
        pend <= 1'b1;
      end
      if (cmd.scan_start) begin
        idx      <= '0;
        ev_valid <= 1'b0;
        found    <= 1'b0;
      end else if (cmd.scan_run) begin
        ev_valid <= (idx < IW'(SLOTS));
        if (idx < IW'(SLOTS)) idx <= idx + 1'b1;
        if (ev_hit && (!found || (ev_key < best_key))) found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ev_idx <= idx[SW-1:0];
    if (cmd.scan_run && ev_hit && (!found || (ev_key < best_key))) begin
      best      <= ev_idx;
      best_key  <= ev_key;
      best_due  <= ev_due;
      best_per  <= rdata[2 +: PER_W];
      best_mode <= rdata[1:0];
    end
    if (cmd.take) begin
      out_slot <= slot;
      out_time <= '0;
      if (action_t'(action) == ACT_SCHED) begin
        out_kind <= sched_ok ? KIND_ACCEPT : KIND_REJECT;
      end else begin
        out_kind <= cancel_ok ? KIND_ACCEPT : KIND_REJECT;
      end
    end else if (cmd.fire) begin
      out_kind <= KIND_FIRED;
      out_slot <= 4'(best);
      out_time <= best_due;
    end
  end

  always_comb begin
    sts.scan_done = cmd.scan_run && (idx == IW'(SLOTS)) && !ev_valid;
    sts.found     = found;
    sts.pend      = pend;
    sts.last      = is_req || !found || at_cap;
  end

  assign kind       = out_kind;
  assign fired_slot = out_slot;
  assign fire_time  = out_time;
  assign last       = sts.last;
  assign overflow   = !is_req && found && at_cap;

endmodule
